// ===== hdl/lhs_pkg.sv =====
package lhs_pkg;

    localparam int Q_W              = 32;
    localparam int Q_FRAC           = 8;
    localparam int WEIGHT_W         = 16;
    localparam int NUM_BINS         = 6;
    localparam int NUM_EDGES        = 5;
    localparam int NUM_EST          = 3;
    localparam int EDGE_W           = 24;
    localparam int BIN_W            = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int LATENCY_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF   = 32;

    typedef logic [NUM_EDGES-1:0][EDGE_W-1:0] lhs_edge_set_t;
    typedef logic [NUM_EST-1:0][WEIGHT_W-1:0] lhs_weight_set_t;

    // reset thresholds, lowest bucket first
    localparam lhs_edge_set_t EDGE_RESET = {
        24'd1000, 24'd500, 24'd100, 24'd50, 24'd10
    };

    // q0.16 weights; keep + new = 1.0 for each estimate
    localparam lhs_weight_set_t W_NEW  = {16'd655, 16'd3277, 16'd6554};
    localparam lhs_weight_set_t W_KEEP = {16'd64881, 16'd62259, 16'd58982};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_ONE   = 3'd0,
        CFG_EDGE_TWO   = 3'd1,
        CFG_EDGE_THREE = 3'd2,
        CFG_EDGE_FOUR  = 3'd3,
        CFG_EDGE_FIVE  = 3'd4
    } lhs_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } lhs_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lhs_unit_stat_t;

endpackage

// ===== hdl/lhs_div.sv =====
module lhs_div #(
    parameter int W = lhs_pkg::Q_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [W-1:0]            dividend,
    input  logic [W-1:0]            divisor,
    output logic [W-1:0]            quotient,
    output lhs_pkg::lhs_unit_stat_t stat
);
    import lhs_pkg::*;

    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic          fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/lhs_ema.sv =====
module lhs_ema #(
    parameter int W  = lhs_pkg::Q_W,
    parameter int WB = lhs_pkg::WEIGHT_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [W-1:0]            acc,
    input  logic [W-1:0]            x,
    input  logic [WB-1:0]           keep_w,
    input  logic [WB-1:0]           new_w,
    output logic [W-1:0]            result,
    output lhs_pkg::lhs_unit_stat_t stat
);
    import lhs_pkg::*;

    localparam int CW = $clog2(WB);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W:0]    hi_reg, hi_next;
    logic [WB-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  part;
    logic [W+1:0]  rounded;

    // weight bits lsb first, partial product shifts right into lo_reg
    assign part = (W+2)'(hi_reg)
                + (keep_w[cnt_reg] ? (W+2)'(acc_reg) : '0)
                + (new_w[cnt_reg]  ? (W+2)'(x_reg)   : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = acc;
            x_next    = x;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = part[W+1:1];
            lo_next  = {part[0], lo_reg[WB-1:1]};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    // round half up: the carry of lo + half is the top lo bit
    assign rounded   = (W+2)'(hi_reg) + (W+2)'(lo_reg[WB-1]);
    assign result    = (rounded[W+1:W] != '0) ? '1 : rounded[W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/lhs_bin.sv =====
module lhs_bin (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lhs_pkg::Q_W-1:0]    sample,
    input  lhs_pkg::lhs_edge_set_t     edges,
    output logic [lhs_pkg::BIN_W-1:0]  bin,
    output lhs_pkg::lhs_unit_stat_t    stat
);
    import lhs_pkg::*;

    logic [BIN_W-1:0] idx_reg, idx_next;
    logic [Q_W-1:0]   smp_reg, smp_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             below;

    // one threshold per cycle, lowest first; first one above the sample wins
    assign below = (smp_reg < Q_W'(edges[idx_reg]));

    always_comb
    begin
        idx_next  = idx_reg;
        smp_next  = smp_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            idx_next  = '0;
            smp_next  = sample;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (below)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + BIN_W'(1);
                if (idx_reg == BIN_W'(NUM_EDGES - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    assign bin       = idx_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/latency_histogram_stats.sv =====
// Latency histogram and running statistics. Each word on the s_ side carries
// one latency sample in ms; each word on the m_ side carries the statistics
// after that sample: saturating sample count, the bucket the sample fell in
// and that bucket's new count, the running mean and three exponential
// estimates (weights 0.1, 0.05, 0.01), all in unsigned Q24.8 ms. The first
// sample seeds the estimates. Five bucket thresholds (exclusive upper bounds,
// checked in order) are written through the cfg port; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Indexes past the last threshold are ignored. One sample is worked at a
// time, from accept to the next accept: the block takes the word, sets up,
// runs the 32 steps of the bit-serial divider that forms the mean step
// (mean + (sample - mean) / count), sees the divider's done flag and then
// commits the result. The estimates (16-step shift-add multipliers) and the
// bucket search run alongside the divider. A new sample is taken while the
// last result still waits on m_tready; the commit of a result waits until
// the output register is free.
module latency_histogram_stats #(
    parameter int LATENCY_BITS = lhs_pkg::LATENCY_BITS_DEF,
    parameter int COUNT_BITS   = lhs_pkg::COUNT_BITS_DEF,
    localparam int S_TDATA_W   = ((LATENCY_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,    // sample_ms

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // samples_seen, bin_hit, bin_total, mean_fx, median_est, high_est,
    // tail_est, zero pad
    output logic [199:0]                  m_tdata,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lhs_pkg::EDGE_W-1:0]    cfg_data
);
    import lhs_pkg::*;

    // counters saturate at the narrower of COUNT_BITS and the output width
    localparam int CNT_W = (COUNT_BITS > Q_W) ? Q_W : COUNT_BITS;
    localparam int OUT_W = 7 * Q_W - Q_W + BIN_W;

    lhs_state_t state_reg, state_next;

    // thresholds
    lhs_edge_set_t edges_reg;

    // running state
    logic [CNT_W-1:0] bin_cnt_reg [NUM_BINS];
    logic [CNT_W-1:0] total_reg;
    logic [Q_W-1:0]   mean_reg;
    logic [Q_W-1:0]   est_reg [NUM_EST];

    // current sample
    logic [LATENCY_BITS-1:0] smp_reg;
    logic [Q_W-1:0]          xq_reg;
    logic [CNT_W-1:0]        n_reg;
    logic                    neg_reg;

    // output register
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    // datapath
    logic [Q_W-1:0]      smp_ext;
    logic [Q_W-1:0]      xq_in;
    logic [Q_W-1:0]      mag;
    logic [Q_W-1:0]      quo;
    logic [Q_W-1:0]      est_new [NUM_EST];
    logic [Q_W-1:0]      est_commit [NUM_EST];
    logic [Q_W-1:0]      mean_commit;
    logic [BIN_W-1:0]    bin;
    logic [CNT_W-1:0]    bin_cnt_new;
    logic                first;
    logic                take_in;
    logic                commit;
    logic                out_free;
    logic                start;
    logic                units_busy;
    lhs_unit_stat_t      div_stat;
    lhs_unit_stat_t      bin_stat;
    lhs_unit_stat_t      ema_stat [NUM_EST];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign take_in   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign start     = (state_reg == ST_LOAD);
    assign units_busy = bin_stat.busy || ema_stat[0].busy || ema_stat[1].busy
                     || ema_stat[2].busy;
    assign commit    = (state_reg == ST_DONE) && out_free && !units_busy;

    // sample to q24.8, saturating when it does not fit 24 integer bits
    assign smp_ext = Q_W'(s_tdata[LATENCY_BITS-1:0]);
    assign xq_in   = (smp_ext[Q_W-1:Q_W-Q_FRAC] != '0) ? '1
                   : {smp_ext[Q_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}};

    // distance from the mean; sign kept for the commit
    assign mag = neg_reg ? (mean_reg - xq_reg) : (xq_reg - mean_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // divider is the longest unit
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    lhs_div #(
        .W (Q_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (mag),
        .divisor  (Q_W'(n_reg)),
        .quotient (quo),
        .stat     (div_stat)
    );

    lhs_bin u_bin (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (Q_W'(smp_reg)),
        .edges  (edges_reg),
        .bin    (bin),
        .stat   (bin_stat)
    );

    for (genvar k = 0; k < NUM_EST; k++)
    begin : g_ema
        lhs_ema #(
            .W  (Q_W),
            .WB (WEIGHT_W)
        ) u_ema (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .acc    (est_reg[k]),
            .x      (xq_reg),
            .keep_w (W_KEEP[k]),
            .new_w  (W_NEW[k]),
            .result (est_new[k]),
            .stat   (ema_stat[k])
        );

        // first sample seeds the estimate
        assign est_commit[k] = first ? xq_reg : est_new[k];
    end

    assign first       = (n_reg == CNT_W'(1));
    assign mean_commit = neg_reg ? (mean_reg - quo) : (mean_reg + quo);
    assign bin_cnt_new = (bin_cnt_reg[bin] == '1) ? bin_cnt_reg[bin]
                       : bin_cnt_reg[bin] + CNT_W'(1);

    // sample capture
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            smp_reg <= s_tdata[LATENCY_BITS-1:0];
            xq_reg  <= xq_in;
            neg_reg <= (xq_in < mean_reg);
            n_reg   <= (total_reg == '1) ? total_reg : total_reg + CNT_W'(1);
        end
    end

    // thresholds and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg <= EDGE_RESET;
            total_reg <= '0;
            mean_reg  <= '0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_EST; i++)
            begin
                est_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EDGE_ONE:   edges_reg[0] <= cfg_data;
                    CFG_EDGE_TWO:   edges_reg[1] <= cfg_data;
                    CFG_EDGE_THREE: edges_reg[2] <= cfg_data;
                    CFG_EDGE_FOUR:  edges_reg[3] <= cfg_data;
                    CFG_EDGE_FIVE:  edges_reg[4] <= cfg_data;
                    default:        ;
                endcase
            end
            if (commit)
            begin
                total_reg        <= n_reg;
                mean_reg         <= mean_commit;
                bin_cnt_reg[bin] <= bin_cnt_new;
                for (int i = 0; i < NUM_EST; i++)
                begin
                    est_reg[i] <= est_commit[i];
                end
            end
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_data_reg <= {est_commit[2], est_commit[1], est_commit[0],
                           mean_commit, Q_W'(bin_cnt_new), bin, Q_W'(n_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(200 - OUT_W){1'b0}}, m_data_reg};

endmodule
